// ===== design/next_lexicographic_permutation_macros.svh =====
// Assertion helpers shared by the permutation block.
`ifndef NEXT_LEXICOGRAPHIC_PERMUTATION_MACROS_SVH
`define NEXT_LEXICOGRAPHIC_PERMUTATION_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define NLP_ASSERT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("nlp assertion failed");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define NLP_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("nlp assertion failed");

`endif

// ===== design/nlp_pkg.sv =====
`default_nettype none

package nlp_pkg;

   localparam int ELEM_W     = 4;
   localparam int POS_W      = 4;
   localparam int RES_ELEMS  = 10;
   localparam int RES_W      = ELEM_W * RES_ELEMS;
   localparam int LENGTH_DEF = 10;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic load_write;
      logic scan_start;
      logic scan_step;
      logic piv_take;
      logic succ_step;
      logic swap;
      logic wrap_start;
      logic sort_step;
      logic publish;
   } nlp_cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic rise_hit;
      logic idx_zero;
      logic gt_hit;
      logic pass_last;
   } nlp_sts_type;

endpackage

`default_nettype wire

// ===== design/nlp_datapath.sv =====
`default_nettype none

`include "next_lexicographic_permutation_macros.svh"

module nlp_datapath #(
   parameter int LENGTH = nlp_pkg::LENGTH_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic [nlp_pkg::POS_W-1:0]     req_position,
   input  wire logic [nlp_pkg::ELEM_W-1:0]    req_element_value,
   input  wire nlp_pkg::nlp_cmd_type          cmd,
   output nlp_pkg::nlp_sts_type               sts,
   output logic      [nlp_pkg::RES_W-1:0]     rsp_sequence_res,
   output logic                               rsp_wrapped
);
   import nlp_pkg::*;

   localparam int IDX_W  = $clog2(LENGTH);
   localparam int CNT_W  = $clog2(LENGTH + 1);
   localparam int PACK_N = (LENGTH < RES_ELEMS) ? LENGTH : RES_ELEMS;

   logic [ELEM_W-1:0] seq_ff [LENGTH];
   logic [ELEM_W-1:0] seq_in [LENGTH];
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [IDX_W-1:0]  piv_ff, piv_in;
   logic [IDX_W-1:0]  lo_ff, lo_in;
   logic [ELEM_W-1:0] pivval_ff, pivval_in;
   logic [CNT_W-1:0]  pass_ff, pass_in;
   logic              phase_ff, phase_in;
   logic              wrap_ff, wrap_in;
   logic [RES_W-1:0]  rsp_seq_ff, rsp_seq_in;
   logic              rsp_wrap_ff, rsp_wrap_in;

   logic [LENGTH-1:0] rise_vec;
   logic [LENGTH-1:0] gt_vec;
   logic [ELEM_W-1:0] rd_elem;
   logic [RES_W-1:0]  packed_seq;

   // Compare neighbors and compare every element against the pivot value
   always_comb begin
      rise_vec = '0;
      gt_vec   = '0;
      for (int i = 0; i < LENGTH - 1; i++) begin
         rise_vec[i] = seq_ff[i] < seq_ff[i+1];
      end
      for (int i = 0; i < LENGTH; i++) begin
         gt_vec[i] = seq_ff[i] > pivval_ff;
      end
   end

   // Single read port at the scan index
   assign rd_elem = seq_ff[idx_ff];

   // Report scan status to the controller
   always_comb begin
      sts.rise_hit  = rise_vec[idx_ff];
      sts.idx_zero  = (idx_ff == '0);
      sts.gt_hit    = gt_vec[idx_ff];
      sts.pass_last = (pass_ff == CNT_W'(1));
   end

   // Pack the visible elements, element 0 lowest
   always_comb begin
      packed_seq = '0;
      for (int i = 0; i < PACK_N; i++) begin
         packed_seq[i*ELEM_W +: ELEM_W] = seq_ff[i];
      end
   end

   // Next-state logic for the sequence and the working registers
   always_comb begin
      seq_in      = seq_ff;
      idx_in      = idx_ff;
      piv_in      = piv_ff;
      lo_in       = lo_ff;
      pivval_in   = pivval_ff;
      pass_in     = pass_ff;
      phase_in    = phase_ff;
      wrap_in     = wrap_ff;
      rsp_seq_in  = rsp_seq_ff;
      rsp_wrap_in = rsp_wrap_ff;

      // write one element; a position past the end matches no cell
      if (cmd.load_write) begin
         wrap_in = 1'b0;
         for (int i = 0; i < LENGTH; i++) begin
            if (req_position == POS_W'(i)) begin
               seq_in[i] = req_element_value;
            end
         end
      end

      // walk down from the last neighbor pair looking for a rise
      if (cmd.scan_start) begin
         idx_in  = IDX_W'(LENGTH - 2);
         wrap_in = 1'b0;
      end
      if (cmd.scan_step) begin
         idx_in = idx_ff - 1'b1;
      end

      // hold the pivot and restart the walk at the end for the successor
      if (cmd.piv_take) begin
         piv_in    = idx_ff;
         pivval_in = rd_elem;
         idx_in    = IDX_W'(LENGTH - 1);
      end
      if (cmd.succ_step) begin
         idx_in = idx_ff - 1'b1;
      end

      // exchange pivot and successor, then sort the tail after the pivot
      if (cmd.swap) begin
         for (int i = 0; i < LENGTH; i++) begin
            if (IDX_W'(i) == piv_ff) begin
               seq_in[i] = rd_elem;
            end else if (IDX_W'(i) == idx_ff) begin
               seq_in[i] = pivval_ff;
            end
         end
         lo_in    = piv_ff + 1'b1;
         pass_in  = CNT_W'(LENGTH - 1) - CNT_W'(piv_ff);
         phase_in = 1'b0;
      end

      // no rise: the whole sequence gets sorted ascending
      if (cmd.wrap_start) begin
         wrap_in  = 1'b1;
         lo_in    = '0;
         pass_in  = CNT_W'(LENGTH);
         phase_in = 1'b0;
      end

      // one odd-even transposition pass over the tail; a non-increasing
      // tail sorted ascending equals the tail reversed
      if (cmd.sort_step) begin
         for (int i = 0; i < LENGTH - 1; i++) begin
            if ((1'(i % 2) == phase_ff) && (IDX_W'(i) >= lo_ff) &&
                (seq_ff[i] > seq_ff[i+1])) begin
               seq_in[i]   = seq_ff[i+1];
               seq_in[i+1] = seq_ff[i];
            end
         end
         pass_in  = pass_ff - 1'b1;
         phase_in = ~phase_ff;
      end

      // capture the finished result
      if (cmd.publish) begin
         rsp_seq_in  = packed_seq;
         rsp_wrap_in = wrap_ff;
      end
   end

   // Sequence store, identity after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LENGTH; i++) begin
            seq_ff[i] <= ELEM_W'(i);
         end
         pass_ff <= '0;
      end else begin
         seq_ff  <= seq_in;
         pass_ff <= pass_in;
      end
   end

   // Working and result registers
   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      piv_ff      <= piv_in;
      lo_ff       <= lo_in;
      pivval_ff   <= pivval_in;
      phase_ff    <= phase_in;
      wrap_ff     <= wrap_in;
      rsp_seq_ff  <= rsp_seq_in;
      rsp_wrap_ff <= rsp_wrap_in;
   end

   assign rsp_sequence_res = rsp_seq_ff;
   assign rsp_wrapped      = rsp_wrap_ff;

   `NLP_ASSERT(a_pivot_is_rise, cmd.piv_take, rise_vec[idx_ff])
   `NLP_ASSERT(a_swap_past_pivot, cmd.swap, (idx_ff > piv_ff) && gt_vec[idx_ff])
   `NLP_ASSERT(a_sort_has_passes, cmd.sort_step, pass_ff != '0)

endmodule

`default_nettype wire

// ===== design/nlp_ctrl.sv =====
`default_nettype none

`include "next_lexicographic_permutation_macros.svh"

module nlp_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic                  req_type,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   input  wire nlp_pkg::nlp_sts_type  sts,
   output nlp_pkg::nlp_cmd_type       cmd
);
   import nlp_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_SCAN = 5'b00010,
      S_SUCC = 5'b00100,
      S_SORT = 5'b01000,
      S_DONE = 5'b10000
   } nlp_state_type;

   nlp_state_type state_ff, state_in;
   logic          rsp_valid_ff, rsp_valid_in;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // Sequence the work of one item
   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (req_type) begin
                  cmd.scan_start = 1'b1;
                  state_in       = S_SCAN;
               end else begin
                  cmd.load_write = 1'b1;
                  state_in       = S_DONE;
               end
            end
         end
         S_SCAN: begin
            priority if (sts.rise_hit) begin
               cmd.piv_take = 1'b1;
               state_in     = S_SUCC;
            end else if (sts.idx_zero) begin
               cmd.wrap_start = 1'b1;
               state_in       = S_SORT;
            end else begin
               cmd.scan_step = 1'b1;
            end
         end
         S_SUCC: begin
            if (sts.gt_hit) begin
               cmd.swap = 1'b1;
               state_in = S_SORT;
            end else begin
               cmd.succ_step = 1'b1;
            end
         end
         S_SORT: begin
            cmd.sort_step = 1'b1;
            if (sts.pass_last) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.publish = 1'b1;
               state_in    = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Hold the result valid until its transfer
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.publish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `NLP_ASSERT(a_publish_slot_free, cmd.publish, !rsp_valid_ff || rsp_ready)
   `NLP_ASSERT_NEXT(a_publish_shows_valid, cmd.publish, rsp_valid_ff)
   `NLP_ASSERT_NEXT(a_rsp_held, rsp_valid_ff && !rsp_ready, rsp_valid_ff)

endmodule

`default_nettype wire

// ===== design/next_lexicographic_permutation.sv =====
`default_nettype none

// Channel  Handshake             Payload
// req      req_valid/req_ready   req_type, req_position, req_element_value
// rsp      rsp_valid/rsp_ready   rsp_sequence_res, rsp_wrapped
//
// A load writes its element, then the result is published to the result register
// once the slot is free. An advance walks down for the pivot, then for its
// successor (no successor walk on wrap), then runs odd-even sort passes over the
// tail after the pivot (over the whole sequence on wrap); one walk or pass a cycle.
// Reset (synchronous) loads the identity sequence and empties the result slot.
// A new item is taken while a finished result still waits in the slot.

module next_lexicographic_permutation #(
   parameter int LENGTH = nlp_pkg::LENGTH_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic                          req_type,
   input  wire logic [nlp_pkg::POS_W-1:0]     req_position,
   input  wire logic [nlp_pkg::ELEM_W-1:0]    req_element_value,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic      [nlp_pkg::RES_W-1:0]     rsp_sequence_res,
   output logic                               rsp_wrapped
);
   import nlp_pkg::*;

   nlp_cmd_type cmd;
   nlp_sts_type sts;

   nlp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_type  (req_type),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   nlp_datapath #(
      .LENGTH (LENGTH)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .req_position      (req_position),
      .req_element_value (req_element_value),
      .cmd               (cmd),
      .sts               (sts),
      .rsp_sequence_res  (rsp_sequence_res),
      .rsp_wrapped       (rsp_wrapped)
   );

endmodule

`default_nettype wire
